/* hw/rtl/rfr_pkg.sv */
// radar frame reassembler package: sizes, packet class codes, result types
// used by rfr_core, rfr_out_fifo and radar_frame_reassembler_top; no dependencies
`default_nettype none

package rfr_pkg;

  localparam int unsigned BUFFER_BYTES = 4194304;
  localparam int unsigned HEADER_BYTES = 40;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned OFFSET_W     = 23;
  localparam int unsigned ADDR_W       = 22;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);

  localparam logic [OFFSET_W-1:0] THRESHOLD_RESET = 23'd3000000;
  localparam logic [OFFSET_W-1:0] BUFFER_LIMIT    = OFFSET_W'(BUFFER_BYTES);

  localparam logic [31:0] MAGIC_HEAD_A = 32'h00BE0001;
  localparam logic [31:0] MAGIC_HEAD_B = 32'hEFBE0001;
  localparam logic [31:0] MAGIC_BODY   = 32'h00000001;
  localparam logic [31:0] MAGIC_TAIL   = 32'hEF000001;

  localparam logic [1:0] CLS_IGNORED = 2'd0;
  localparam logic [1:0] CLS_HEAD    = 2'd1;
  localparam logic [1:0] CLS_BODY    = 2'd2;
  localparam logic [1:0] CLS_TAIL    = 2'd3;

  localparam logic KIND_STORE    = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   store_address;
    logic [7:0]          store_value;
    logic [OFFSET_W-1:0] frame_length;
    logic [COUNT_W-1:0]  dropped_frames;
    logic [COUNT_W-1:0]  total_frames;
    logic                is_last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

`default_nettype wire

/* hw/rtl/rfr_core.sv */
// rfr_core: header parsing, frame bookkeeping and result generation per byte
// depends on rfr_pkg
`default_nettype none

module rfr_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [7:0]                   byte_i,
  input  wire logic                         end_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [rfr_pkg::OFFSET_W-1:0] cfg_wdata_i,
  output rfr_pkg::push_t                    push_o
);
  import rfr_pkg::*;

  localparam logic [POS_W-1:0] HdrPos  = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] LastHdr = POS_W'(HEADER_BYTES - 1);

  logic [POS_W-1:0]    pos_q, pos_d;
  logic [31:0]         magic_q, magic_d;
  logic [31:0]         fid_q, fid_d;
  logic [1:0]          cls_q, cls_d;
  logic                coll_q, coll_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [31:0]         prev_q, prev_d;
  logic [COUNT_W-1:0]  drop_q, drop_d;
  logic [COUNT_W-1:0]  frame_q, frame_d;
  logic [OFFSET_W-1:0] thr_q;

  logic                store;
  logic                done;
  logic [OFFSET_W-1:0] done_len;
  logic [31:0]         skip_add;
  res_t                res_store;
  res_t                res_done;

  always_comb begin
    pos_d    = pos_q;
    magic_d  = magic_q;
    fid_d    = fid_q;
    cls_d    = cls_q;
    coll_d   = coll_q;
    offset_d = offset_q;
    prev_d   = prev_q;
    drop_d   = drop_q;
    frame_d  = frame_q;
    store    = 1'b0;
    done     = 1'b0;
    done_len = offset_q;
    skip_add = '0;
    if (step_i) begin
      if (pos_q < HdrPos) begin
        if (pos_q >= 6'd12 && pos_q <= 6'd15) begin
          magic_d = {byte_i, magic_q[31:8]};
        end else if (pos_q >= 6'd16 && pos_q <= 6'd19) begin
          fid_d = {byte_i, fid_q[31:8]};
        end
        if (pos_q == LastHdr) begin
          if (magic_d == MAGIC_HEAD_A || magic_d == MAGIC_HEAD_B) begin
            cls_d = CLS_HEAD;
          end else if (magic_d == MAGIC_BODY) begin
            cls_d = CLS_BODY;
          end else if (magic_d == MAGIC_TAIL) begin
            cls_d = CLS_TAIL;
          end else begin
            cls_d = CLS_IGNORED;
          end
          if (cls_d == CLS_HEAD) begin
            // skipped frame ids count as drops
            if (prev_q != '0 && fid_d > prev_q + 32'd1) begin
              skip_add = fid_d - prev_q - 32'd1;
            end
            drop_d   = drop_q + skip_add + {31'd0, coll_q};
            frame_d  = frame_q + {31'd0, ~coll_q};
            prev_d   = fid_d;
            offset_d = '0;
            coll_d   = 1'b1;
          end
        end
        pos_d = pos_q + 6'd1;
      end else if (cls_q != CLS_IGNORED && coll_q && offset_q < BUFFER_LIMIT) begin
        store    = 1'b1;
        offset_d = offset_q + 23'd1;
      end
      if (end_i) begin
        if (pos_q >= LastHdr && cls_d == CLS_TAIL && coll_d) begin
          if (offset_d > thr_q) begin
            done     = 1'b1;
            done_len = offset_d;
            offset_d = '0;
          end
          coll_d = 1'b0;
        end
        pos_d   = '0;
        magic_d = '0;
        fid_d   = '0;
        cls_d   = CLS_IGNORED;
      end
    end
  end

  always_comb begin
    res_store.kind           = KIND_STORE;
    res_store.store_address  = offset_q[ADDR_W-1:0];
    res_store.store_value    = byte_i;
    res_store.frame_length   = '0;
    res_store.dropped_frames = drop_d;
    res_store.total_frames   = frame_d;
    res_store.is_last        = ~done;

    res_done.kind           = KIND_COMPLETE;
    res_done.store_address  = '0;
    res_done.store_value    = '0;
    res_done.frame_length   = done_len;
    res_done.dropped_frames = drop_d;
    res_done.total_frames   = frame_d;
    res_done.is_last        = 1'b1;

    push_o.cnt    = 2'({1'b0, store} + {1'b0, done});
    push_o.first  = store ? res_store : res_done;
    push_o.second = res_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      magic_q  <= '0;
      fid_q    <= '0;
      cls_q    <= CLS_IGNORED;
      coll_q   <= 1'b0;
      offset_q <= '0;
      prev_q   <= '0;
      drop_q   <= '0;
      frame_q  <= '0;
      thr_q    <= THRESHOLD_RESET;
    end else begin
      pos_q    <= pos_d;
      magic_q  <= magic_d;
      fid_q    <= fid_d;
      cls_q    <= cls_d;
      coll_q   <= coll_d;
      offset_q <= offset_d;
      prev_q   <= prev_d;
      drop_q   <= drop_d;
      frame_q  <= frame_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  a_store_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store |-> offset_q < BUFFER_LIMIT)
    else $error("store beyond buffer end");

  a_complete_over_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (done_len > thr_q && step_i && end_i))
    else $error("frame complete without tail end above threshold");

  a_end_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && end_i) |=> (pos_q == '0 && cls_q == CLS_IGNORED && !offset_q[OFFSET_W-1]
                            || pos_q == '0 && cls_q == CLS_IGNORED))
    else $error("packet end did not restart header parsing");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= HdrPos)
    else $error("header position ran past header length");

endmodule

`default_nettype wire

/* hw/rtl/rfr_out_fifo.sv */
// rfr_out_fifo: small result queue taking up to two results per cycle while room_o is set
// depends on rfr_pkg
`default_nettype none

module rfr_out_fifo (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire rfr_pkg::push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output rfr_pkg::res_t out_o
);
  import rfr_pkg::*;

  localparam logic [FIFO_PTR_W:0] Depth   = (FIFO_PTR_W+1)'(FIFO_DEPTH);
  localparam logic [FIFO_PTR_W:0] RoomMax = (FIFO_PTR_W+1)'(FIFO_DEPTH - 2);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;
  logic                  pop;
  logic [FIFO_PTR_W-1:0] wptr_nxt;

  assign room_o      = cnt_q <= RoomMax;
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem[rptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign wptr_nxt    = wptr_q + FIFO_PTR_W'(1);

  always_comb begin
    wptr_d = wptr_q + FIFO_PTR_W'(push_i.cnt);
    rptr_d = rptr_q + FIFO_PTR_W'(pop);
    cnt_d  = cnt_q + (FIFO_PTR_W+1)'(push_i.cnt) - (FIFO_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wptr_nxt] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("result push into full queue");

  a_push_cnt_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd3)
    else $error("more than two results for one byte");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("queue occupancy overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FIFO_PTR_W'(wptr_q - rptr_q) == cnt_q[FIFO_PTR_W-1:0])
    else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

/* hw/rtl/radar_frame_reassembler_top.sv */
// radar frame reassembler top: input register, per-byte core, result queue
// path: input register, core, result queue; throughput: one byte per cycle
// if the queue has room; a byte with a store and a frame-complete result
// needs two output transfers, set by the single result port
// reset: asynchronous active-low; counters, offset, parsing state cleared,
// threshold back to 3000000, result queue emptied
`default_nettype none

module radar_frame_reassembler_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [7:0]                   payload_byte_i,
  input  wire logic                         packet_end_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              kind_o,
  output logic [rfr_pkg::ADDR_W-1:0]        store_address_o,
  output logic [7:0]                        store_value_o,
  output logic [rfr_pkg::OFFSET_W-1:0]      frame_length_o,
  output logic [rfr_pkg::COUNT_W-1:0]       dropped_frames_o,
  output logic [rfr_pkg::COUNT_W-1:0]       total_frames_o,
  output logic                              is_last_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [rfr_pkg::OFFSET_W-1:0] cfg_wdata_i
);
  import rfr_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       room;
  logic       step;
  push_t      push;
  res_t       res;

  assign step       = in_vld_q & room;
  assign in_ready_o = ~in_vld_q | step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= payload_byte_i;
      end_q  <= packet_end_i;
    end
  end

  rfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .end_i       (end_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push)
  );

  rfr_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign kind_o           = res.kind;
  assign store_address_o  = res.store_address;
  assign store_value_o    = res.store_value;
  assign frame_length_o   = res.frame_length;
  assign dropped_frames_o = res.dropped_frames;
  assign total_frames_o   = res.total_frames;
  assign is_last_o        = res.is_last;

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && room && !(in_valid_i && in_ready_o)) |=> !in_vld_q)
    else $error("input stage held after processing");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !room) |-> !in_ready_o)
    else $error("input stage overwritten while stalled");

  a_push_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> step)
    else $error("result produced without a byte in process");

endmodule

`default_nettype wire
